@@ src/ckr_pkg.sv @@
// ============================================================================
// ckr_pkg - shared types and constants of the ChaCha20 keystream RNG
// Block geometry, register map, quarter-round step codes and state words.
// ============================================================================
`default_nettype none

package ckr_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int MAX_REQUEST = 64;
    localparam int WORDS       = 16;
    localparam int LANES       = 4;

    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    // mask on the low counter word that triggers a nonce reseed
    localparam logic [31:0] RESEED_MASK = 32'h0000_0FFF;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FEED,
        S_FETCH,
        S_EMIT
    } state_t;

    // one quarter round = four add / xor / rotate steps
    typedef enum logic [1:0] {
        STEP_AD16,
        STEP_CB12,
        STEP_AD8,
        STEP_CB7
    } step_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_words_t;

    function automatic word_t sigma_word(input logic [1:0] idx);
        word_t w;
        case (idx)
            2'd0:    w = SIGMA0;
            2'd1:    w = SIGMA1;
            2'd2:    w = SIGMA2;
            default: w = SIGMA3;
        endcase
        return w;
    endfunction

    // block input word: constants, key, counter, nonce
    function automatic word_t block_word(
        input logic [3:0]   idx,
        input logic [255:0] key,
        input logic [63:0]  ctr,
        input logic [63:0]  nonce
    );
        logic [2:0] ki;
        word_t      w;
        ki = idx[2:0] - 3'd4;
        if (idx[3:2] == 2'd0)
        begin
            w = sigma_word(idx[1:0]);
        end
        else if (idx[3:2] == 2'd3)
        begin
            case (idx[1:0])
                2'd0:    w = ctr[31:0];
                2'd1:    w = ctr[63:32];
                2'd2:    w = nonce[31:0];
                default: w = nonce[63:32];
            endcase
        end
        else
        begin
            w = key[{ki, 5'b00000} +: 32];
        end
        return w;
    endfunction

    // state word used by a lane: slot 0..3 is a, b, c, d
    function automatic logic [3:0] qr_index(
        input logic [1:0] lane,
        input logic [1:0] slot,
        input logic       diag
    );
        logic [1:0] col;
        col = diag ? (lane + slot) : lane;
        return {slot, col};
    endfunction

endpackage

`default_nettype wire

@@ src/ckr_ram.sv @@
// ============================================================================
// ckr_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module ckr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/ckr_qr_step.sv @@
// ============================================================================
// ckr_qr_step - one step of a ChaCha quarter round
// Add, xor and rotate on one lane's four words; step code picks the pair.
// ============================================================================
`default_nettype none

module ckr_qr_step (
    input  wire ckr_pkg::step_t    step,
    input  wire ckr_pkg::qr_words_t words_in,
    output      ckr_pkg::qr_words_t words_out
);

    ckr_pkg::word_t sum_ab;
    ckr_pkg::word_t sum_cd;
    ckr_pkg::word_t mix_d;
    ckr_pkg::word_t mix_b;

    assign sum_ab = words_in.a + words_in.b;
    assign sum_cd = words_in.c + words_in.d;
    assign mix_d  = words_in.d ^ sum_ab;
    assign mix_b  = words_in.b ^ sum_cd;

    always_comb
    begin
        words_out = words_in;
        case (step)
            ckr_pkg::STEP_AD16:
            begin
                words_out.a = sum_ab;
                words_out.d = {mix_d[15:0], mix_d[31:16]};
            end
            ckr_pkg::STEP_CB12:
            begin
                words_out.c = sum_cd;
                words_out.b = {mix_b[19:0], mix_b[31:20]};
            end
            ckr_pkg::STEP_AD8:
            begin
                words_out.a = sum_ab;
                words_out.d = {mix_d[23:0], mix_d[31:24]};
            end
            ckr_pkg::STEP_CB7:
            begin
                words_out.c = sum_cd;
                words_out.b = {mix_b[24:0], mix_b[31:25]};
            end
            default:
            begin
                words_out = words_in;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/chacha20_keystream_rng.sv @@
// ============================================================================
// chacha20_keystream_rng - ChaCha20 keystream random byte generator
// Hands out keystream bytes per request, refilling a 64-byte block buffer.
// ============================================================================
// Usage:
//   Slave stream: one word is a request, s_tdata = {entropy, count}. Count
//   saturates at 64; a count of zero is dropped with no output and no state
//   change. Master stream: one word per byte, m_tlast on the request's last.
//   Requests are taken one at a time; s_tready is high only while idle.
//   Refill: when the 64-byte buffer is used up, a block is computed in the
//   working registers by four parallel quarter-round lanes, one add/xor/rotate
//   step per cycle, then the feed-forward add writes all 16 words into the
//   keystream RAM, one word a cycle. Bytes: one RAM read per word, then one
//   byte of that word per cycle while the receiver takes them. A stalled
//   receiver simply holds the output register; nothing is lost.
//   Reset: counter 0, nonce 0, keys 0, buffer marked empty (first request
//   refills). The keystream RAM has no reset and is never read unwritten.
//   Config: APB, 64-bit registers at 8*index; write only while idle. Writing
//   the nonce seed also replaces the running nonce at once.
// ============================================================================
`default_nettype none

module chacha20_keystream_rng #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request: [6:0] request_count, [70:7] entropy_sample, [71] zero
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [71:0]                  s_tdata,
    // result: [7:0] random_byte; m_tlast = last_of_request
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [7:0]                   m_tdata,
    output      logic                         m_tlast,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ckr_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [ckr_pkg::CFG_DW-1:0]   pwdata,
    output      logic [ckr_pkg::CFG_DW-1:0]   prdata,
    output      logic                         pready
);

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int HW          = $clog2(HALF_ROUNDS);
    localparam int AW          = $clog2(ckr_pkg::WORDS);

    // ---------------- state ----------------
    ckr_pkg::state_t state_reg, state_next;
    ckr_pkg::step_t  step_reg, step_next;
    logic [HW-1:0]   half_reg, half_next;     // half-round (column/diagonal)
    logic [AW-1:0]   feed_reg, feed_next;     // feed-forward word index
    logic [6:0]      pos_reg, pos_next;       // next byte in buffer, 64 = empty
    logic [6:0]      remain_reg, remain_next; // bytes still owed after current
    logic [63:0]     entropy_reg, entropy_next;
    logic [63:0]     ctr_reg, ctr_next;
    logic [63:0]     nonce_reg, nonce_next;
    logic [63:0]     seed_reg, seed_next;
    logic [63:0]     key_reg [4];
    logic [63:0]     key_next [4];
    ckr_pkg::word_t  x_reg [ckr_pkg::WORDS];
    ckr_pkg::word_t  x_next [ckr_pkg::WORDS];
    ckr_pkg::word_t  word_reg, word_next;     // copy of current buffer word
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;

    // ---------------- keystream RAM ----------------
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    ckr_pkg::word_t  ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    ckr_pkg::word_t  ram_rdata;

    ckr_ram #(
        .WIDTH(32),
        .DEPTH(ckr_pkg::WORDS)
    ) u_buf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- quarter-round lanes ----------------
    ckr_pkg::qr_words_t lane_in  [ckr_pkg::LANES];
    ckr_pkg::qr_words_t lane_out [ckr_pkg::LANES];
    logic               diag;

    assign diag = half_reg[0];

    always_comb
    begin
        for (int j = 0; j < ckr_pkg::LANES; j++)
        begin
            lane_in[j].a = x_reg[ckr_pkg::qr_index(2'(j), 2'd0, diag)];
            lane_in[j].b = x_reg[ckr_pkg::qr_index(2'(j), 2'd1, diag)];
            lane_in[j].c = x_reg[ckr_pkg::qr_index(2'(j), 2'd2, diag)];
            lane_in[j].d = x_reg[ckr_pkg::qr_index(2'(j), 2'd3, diag)];
        end
    end

    for (genvar j = 0; j < ckr_pkg::LANES; j++)
    begin : g_lane
        ckr_qr_step u_step (
            .step      (step_reg),
            .words_in  (lane_in[j]),
            .words_out (lane_out[j])
        );
    end

    // ---------------- handshake and decode ----------------
    logic [6:0]     req_count;
    logic [6:0]     req_sat;
    logic           accept;
    logic           out_fire;
    logic           round_done;
    logic           feed_done;
    logic           cfg_wr;
    logic [2:0]     cfg_idx;
    logic [255:0]   key_packed;
    logic [63:0]    ctr_inc;
    ckr_pkg::word_t x_init [ckr_pkg::WORDS];

    assign s_tready   = (state_reg == ckr_pkg::S_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign req_count  = s_tdata[6:0];
    assign req_sat    = (req_count > 7'(ckr_pkg::MAX_REQUEST)) ?
                        7'(ckr_pkg::MAX_REQUEST) : req_count;
    assign out_fire   = out_valid_reg & m_tready;
    assign round_done = (step_reg == ckr_pkg::STEP_CB7) &&
                        (half_reg == HW'(HALF_ROUNDS - 1));
    assign feed_done  = (feed_reg == AW'(ckr_pkg::WORDS - 1));
    assign cfg_wr     = psel & penable & pwrite & pready;
    assign cfg_idx    = paddr[5:3];
    assign key_packed = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign ctr_inc    = ctr_reg + 64'd1;
    assign pready     = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        for (int i = 0; i < ckr_pkg::WORDS; i++)
        begin
            x_init[i] = ckr_pkg::block_word(4'(i), key_packed, ctr_reg, nonce_reg);
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ckr_pkg::S_IDLE:
            begin
                if (accept && (req_sat != 7'd0))
                begin
                    state_next = pos_reg[6] ? ckr_pkg::S_ROUND : ckr_pkg::S_FETCH;
                end
            end
            ckr_pkg::S_ROUND:
            begin
                if (round_done)
                begin
                    state_next = ckr_pkg::S_FEED;
                end
            end
            ckr_pkg::S_FEED:
            begin
                if (feed_done)
                begin
                    state_next = ckr_pkg::S_FETCH;
                end
            end
            ckr_pkg::S_FETCH:
            begin
                state_next = ckr_pkg::S_EMIT;
            end
            ckr_pkg::S_EMIT:
            begin
                if (out_fire)
                begin
                    if (remain_reg == 7'd0)
                    begin
                        state_next = ckr_pkg::S_IDLE;
                    end
                    else if (pos_reg[6])
                    begin
                        state_next = ckr_pkg::S_ROUND;
                    end
                    else if (pos_reg[1:0] != 2'd0)
                    begin
                        state_next = ckr_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = ckr_pkg::S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ckr_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        step_next      = step_reg;
        half_next      = half_reg;
        feed_next      = feed_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        entropy_next   = entropy_reg;
        ctr_next       = ctr_reg;
        nonce_next     = nonce_reg;
        seed_next      = seed_reg;
        key_next       = key_reg;
        x_next         = x_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = feed_reg;
        ram_wdata      = x_reg[feed_reg] +
                         ckr_pkg::block_word(feed_reg, key_packed, ctr_reg, nonce_reg);
        ram_re         = 1'b0;
        ram_raddr      = pos_reg[5:2];

        case (state_reg)
            ckr_pkg::S_IDLE:
            begin
                if (accept && (req_sat != 7'd0))
                begin
                    remain_next  = req_sat;
                    entropy_next = s_tdata[70:7];
                    if (pos_reg[6])
                    begin
                        x_next    = x_init;
                        half_next = '0;
                        step_next = ckr_pkg::STEP_AD16;
                        feed_next = '0;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            ckr_pkg::S_ROUND:
            begin
                for (int j = 0; j < ckr_pkg::LANES; j++)
                begin
                    x_next[ckr_pkg::qr_index(2'(j), 2'd0, diag)] = lane_out[j].a;
                    x_next[ckr_pkg::qr_index(2'(j), 2'd1, diag)] = lane_out[j].b;
                    x_next[ckr_pkg::qr_index(2'(j), 2'd2, diag)] = lane_out[j].c;
                    x_next[ckr_pkg::qr_index(2'(j), 2'd3, diag)] = lane_out[j].d;
                end
                step_next = ckr_pkg::step_t'(step_reg + 2'd1);
                if (step_reg == ckr_pkg::STEP_CB7)
                begin
                    half_next = half_reg + HW'(1);
                end
            end
            ckr_pkg::S_FEED:
            begin
                ram_we    = 1'b1;
                feed_next = feed_reg + AW'(1);
                if (feed_done)
                begin
                    // block done: bump counter, maybe reseed, rewind buffer
                    ctr_next = ctr_inc;
                    if ((ctr_inc[31:0] & ckr_pkg::RESEED_MASK) == 32'd0)
                    begin
                        nonce_next = nonce_reg ^ entropy_reg;
                    end
                    pos_next  = 7'd0;
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            ckr_pkg::S_FETCH:
            begin
                word_next      = ram_rdata;
                out_valid_next = 1'b1;
                out_byte_next  = ram_rdata[{pos_reg[1:0], 3'b000} +: 8];
                out_last_next  = (remain_reg == 7'd1);
                pos_next       = pos_reg + 7'd1;
                remain_next    = remain_reg - 7'd1;
            end
            ckr_pkg::S_EMIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (remain_reg != 7'd0)
                    begin
                        if (pos_reg[6])
                        begin
                            x_next    = x_init;
                            half_next = '0;
                            step_next = ckr_pkg::STEP_AD16;
                            feed_next = '0;
                        end
                        else if (pos_reg[1:0] != 2'd0)
                        begin
                            // rest of the word is already held locally
                            out_valid_next = 1'b1;
                            out_byte_next  = word_reg[{pos_reg[1:0], 3'b000} +: 8];
                            out_last_next  = (remain_reg == 7'd1);
                            pos_next       = pos_reg + 7'd1;
                            remain_next    = remain_reg - 7'd1;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase

        // register writes (user writes only while idle; the block does not enforce it)
        if (cfg_wr)
        begin
            case (cfg_idx)
                ckr_pkg::REG_KEY01: key_next[0] = pwdata;
                ckr_pkg::REG_KEY23: key_next[1] = pwdata;
                ckr_pkg::REG_KEY45: key_next[2] = pwdata;
                ckr_pkg::REG_KEY67: key_next[3] = pwdata;
                ckr_pkg::REG_NONCE:
                begin
                    seed_next  = pwdata;
                    nonce_next = pwdata;
                end
                default:
                begin
                    seed_next = seed_reg;
                end
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (cfg_idx)
            ckr_pkg::REG_KEY01: prdata = key_reg[0];
            ckr_pkg::REG_KEY23: prdata = key_reg[1];
            ckr_pkg::REG_KEY45: prdata = key_reg[2];
            ckr_pkg::REG_KEY67: prdata = key_reg[3];
            ckr_pkg::REG_NONCE: prdata = seed_reg;
            default:            prdata = '0;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ckr_pkg::S_IDLE;
            step_reg      <= ckr_pkg::STEP_AD16;
            half_reg      <= '0;
            feed_reg      <= '0;
            pos_reg       <= 7'(ckr_pkg::BLOCK_BYTES);
            remain_reg    <= '0;
            ctr_reg       <= '0;
            nonce_reg     <= '0;
            seed_reg      <= '0;
            key_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            half_reg      <= half_next;
            feed_reg      <= feed_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            ctr_reg       <= ctr_next;
            nonce_reg     <= nonce_next;
            seed_reg      <= seed_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entropy_reg  <= entropy_next;
        x_reg        <= x_next;
        word_reg     <= word_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // ---------------- assertions ----------------
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ckr_pkg::S_EMIT))
        else $error("output valid outside emit state");

    a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ckr_pkg::S_FETCH) |-> $past(ram_re))
        else $error("fetch state without a preceding buffer read");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!pos_reg[6] || (state_reg == ckr_pkg::S_FEED)))
        else $error("buffer read while empty");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last_reg) |=> (state_reg == ckr_pkg::S_IDLE))
        else $error("request not finished after its last byte");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(pos_reg[6] && (pos_reg[5:0] != 6'd0)))
        else $error("buffer position beyond block");

endmodule

`default_nettype wire
